// ===== hdl/arp_pkg.sv =====
// ----------------------------------------------------------------------------
// arp_pkg
// Shared types, command and result codes for the address resolution cache.
// ----------------------------------------------------------------------------
package arp_pkg;

  localparam int CACHE_ENTRIES_DEF   = 16;
  localparam int PENDING_ENTRIES_DEF = 8;

  localparam logic [7:0] TIMEOUT_RST = 8'd15;
  localparam logic [3:0] GAP_RST     = 4'd1;
  localparam logic [3:0] LIMIT_RST   = 4'd5;
  localparam logic [3:0] NEW_WAIT    = 4'd15;

  typedef enum logic [1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_QUEUE  = 2'd1,
    CMD_REPLY  = 2'd2,
    CMD_TICK   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    KIND_LOOKUP  = 3'd0,
    KIND_QACK    = 3'd1,
    KIND_RACK    = 3'd2,
    KIND_SEND    = 3'd3,
    KIND_UNREACH = 3'd4,
    KIND_IDLE    = 3'd5
  } kind_t;

  localparam logic [1:0] REG_TIMEOUT = 2'd0;
  localparam logic [1:0] REG_GAP     = 2'd1;
  localparam logic [1:0] REG_LIMIT   = 2'd2;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] ip_addr;
    logic [47:0] mac_addr;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic        hit;
    logic        table_full;
    logic [31:0] target_ip;
    logic [47:0] found_mac;
    logic        last;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture input beat
    logic exec;      // run lookup / queue / reply, build result
    logic age;       // age the cache
    logic sweep;     // handle pending slot at sweep index
    logic sweep_clr; // reset sweep index
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic sweep_done; // index at last slot
    logic emitted;    // a tick result was emitted so far
  } dp_sts_t;

endpackage

// ===== hdl/arp_cache_with_request_retry.sv =====
// ----------------------------------------------------------------------------
// arp_cache_with_request_retry
// IPv4-to-MAC cache with a pending request table and tick-driven retries.
// ----------------------------------------------------------------------------
// usage
//   in_*  : one command beat (lookup, queue request, reply, tick)
//   out_* : result beats; last marks the final one of a command
//   cfg_* : register writes (entry_timeout, resend_gap, send_limit), idle only
// sequencing
//   lookup, queue and reply: one result beat per command
//   tick: ages the cache, then one sweep step per pending slot; each due slot
//   sends a beat, and a step waits while a result is in flight or held
//   one command at a time; the next beat is taken once the result is drained
// reset
//   synchronous active-low; clears both valid tables and loads register
//   defaults; no clearing pass
// stall
//   a result waits in the output register; the sweep pauses until it drains,
//   and each sweep beat carries last when no later slot is due
// ----------------------------------------------------------------------------
module arp_cache_with_request_retry #(
  parameter int CACHE_ENTRIES   = arp_pkg::CACHE_ENTRIES_DEF,
  parameter int PENDING_ENTRIES = arp_pkg::PENDING_ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  arp_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output arp_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_data
);
  import arp_pkg::*;

  logic [7:0] timeout_r;
  logic [3:0] gap_r;
  logic [3:0] limit_r;

  dp_cmd_t   cmd;
  dp_sts_t   sts;
  logic      res_valid;
  out_item_t res;

  // config writes always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RST;
      gap_r     <= GAP_RST;
      limit_r   <= LIMIT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_TIMEOUT: timeout_r <= cfg_data;
        REG_GAP:     gap_r     <= cfg_data[3:0];
        REG_LIMIT:   limit_r   <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  arp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_cmd    (in_data.command),
    .cmd       (cmd),
    .sts       (sts),
    .res_valid (res_valid),
    .res       (res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  arp_datapath #(
    .CACHE_ENTRIES   (CACHE_ENTRIES),
    .PENDING_ENTRIES (PENDING_ENTRIES)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_item       (in_data),
    .cmd           (cmd),
    .entry_timeout (timeout_r),
    .resend_gap    (gap_r),
    .send_limit    (limit_r),
    .sts           (sts),
    .res_valid     (res_valid),
    .res           (res)
  );

endmodule

// ===== hdl/arp_datapath.sv =====
// ----------------------------------------------------------------------------
// arp_datapath
// Cache and pending tables, searches, ageing and the per-slot tick sweep.
// ----------------------------------------------------------------------------
module arp_datapath #(
  parameter int CACHE_ENTRIES   = arp_pkg::CACHE_ENTRIES_DEF,
  parameter int PENDING_ENTRIES = arp_pkg::PENDING_ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  arp_pkg::in_item_t  in_item,
  input  arp_pkg::dp_cmd_t   cmd,
  input  logic [7:0]         entry_timeout,
  input  logic [3:0]         resend_gap,
  input  logic [3:0]         send_limit,
  output arp_pkg::dp_sts_t   sts,
  output logic               res_valid,
  output arp_pkg::out_item_t res
);
  import arp_pkg::*;

  localparam int CW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam int PW = (PENDING_ENTRIES > 1) ? $clog2(PENDING_ENTRIES) : 1;

  logic [31:0] cache_ip_r   [CACHE_ENTRIES];
  logic [47:0] cache_mac_r  [CACHE_ENTRIES];
  logic [7:0]  cache_age_r  [CACHE_ENTRIES];
  logic [CACHE_ENTRIES-1:0] cache_vld_r;
  logic [31:0] pend_ip_r    [PENDING_ENTRIES];
  logic [3:0]  pend_sends_r [PENDING_ENTRIES];
  logic [3:0]  pend_wait_r  [PENDING_ENTRIES];
  logic [PENDING_ENTRIES-1:0] pend_vld_r;

  in_item_t    item_r;
  logic [PW-1:0] idx_r;
  logic        emitted_r;

  // search results
  logic [CACHE_ENTRIES-1:0]   c_match;
  logic [PENDING_ENTRIES-1:0] p_match;
  logic        c_hit, c_free_f, p_hit, p_free_f;
  logic [CW-1:0] c_hit_idx, c_free_idx;
  logic [PW-1:0] p_hit_idx, p_free_idx;

  always_comb begin
    for (int i = 0; i < CACHE_ENTRIES; i++)
      c_match[i] = cache_vld_r[i] && (cache_ip_r[i] == item_r.ip_addr);
    for (int i = 0; i < PENDING_ENTRIES; i++)
      p_match[i] = pend_vld_r[i] && (pend_ip_r[i] == item_r.ip_addr);
    c_hit = 1'b0; c_hit_idx = '0; c_free_f = 1'b0; c_free_idx = '0;
    for (int i = 0; i < CACHE_ENTRIES; i++) begin
      if (c_match[i]) begin
        c_hit = 1'b1; c_hit_idx = CW'(i);
      end
    end
    for (int i = CACHE_ENTRIES - 1; i >= 0; i--) begin
      if (!cache_vld_r[i]) begin
        c_free_f = 1'b1; c_free_idx = CW'(i);
      end
    end
    p_hit = 1'b0; p_hit_idx = '0; p_free_f = 1'b0; p_free_idx = '0;
    for (int i = PENDING_ENTRIES - 1; i >= 0; i--) begin
      if (p_match[i]) begin
        p_hit = 1'b1; p_hit_idx = PW'(i);
      end
      if (!pend_vld_r[i]) begin
        p_free_f = 1'b1; p_free_idx = PW'(i);
      end
    end
  end

  // sweep slot evaluation
  logic [3:0] s_wait;
  logic       s_due, s_give_up;
  always_comb begin
    s_wait    = (pend_wait_r[idx_r] == 4'd15) ? 4'd15 : pend_wait_r[idx_r] + 4'd1;
    s_due     = pend_vld_r[idx_r] && (s_wait > resend_gap);
    s_give_up = pend_sends_r[idx_r] >= send_limit;
  end

  // any slot after the sweep index still due on this tick
  logic later_due;
  always_comb begin
    later_due = 1'b0;
    for (int j = 0; j < PENDING_ENTRIES; j++) begin
      if ((PW'(j) > idx_r) && pend_vld_r[j] &&
          (((pend_wait_r[j] == 4'd15) ? 4'd15 : pend_wait_r[j] + 4'd1) > resend_gap))
        later_due = 1'b1;
    end
  end

  assign sts.sweep_done = (idx_r == PW'(PENDING_ENTRIES - 1));
  assign sts.emitted    = emitted_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cache_vld_r <= '0;
      pend_vld_r  <= '0;
      res_valid   <= 1'b0;
      idx_r       <= '0;
      emitted_r   <= 1'b0;
    end else begin
      res_valid <= 1'b0;
      if (cmd.load) item_r <= in_item;
      if (cmd.sweep_clr) begin
        idx_r     <= '0;
        emitted_r <= 1'b0;
      end
      if (cmd.exec) begin
        res_valid      <= 1'b1;
        res.target_ip  <= item_r.ip_addr;
        res.last       <= 1'b1;
        res.hit        <= 1'b0;
        res.table_full <= 1'b0;
        res.found_mac  <= '0;
        unique case (cmd_t'(item_r.command))
          CMD_LOOKUP: begin
            res.kind <= KIND_LOOKUP;
            res.hit  <= c_hit;
            if (c_hit) res.found_mac <= cache_mac_r[c_hit_idx];
          end
          CMD_QUEUE: begin
            res.kind <= KIND_QACK;
            if (p_hit) res.hit <= 1'b1;
            else if (!p_free_f) res.table_full <= 1'b1;
            else begin
              pend_vld_r[p_free_idx]   <= 1'b1;
              pend_ip_r[p_free_idx]    <= item_r.ip_addr;
              pend_sends_r[p_free_idx] <= 4'd0;
              pend_wait_r[p_free_idx]  <= NEW_WAIT;
            end
          end
          CMD_REPLY: begin
            res.kind       <= KIND_RACK;
            res.hit        <= p_hit;
            res.table_full <= !c_free_f;
            if (p_hit) pend_vld_r[p_hit_idx] <= 1'b0;
            if (c_free_f) begin
              cache_vld_r[c_free_idx] <= 1'b1;
              cache_ip_r[c_free_idx]  <= item_r.ip_addr;
              cache_mac_r[c_free_idx] <= item_r.mac_addr;
              cache_age_r[c_free_idx] <= 8'd0;
            end
          end
          default: begin
            // tick with nothing due
            res.kind      <= KIND_IDLE;
            res.target_ip <= '0;
          end
        endcase
      end
      if (cmd.age) begin
        for (int i = 0; i < CACHE_ENTRIES; i++) begin
          if (cache_vld_r[i]) begin
            if (cache_age_r[i] != 8'hFF) cache_age_r[i] <= cache_age_r[i] + 8'd1;
            if (((cache_age_r[i] == 8'hFF) ? 8'hFF : cache_age_r[i] + 8'd1)
                > entry_timeout)
              cache_vld_r[i] <= 1'b0;
          end
        end
      end
      if (cmd.sweep) begin
        if (!sts.sweep_done) idx_r <= idx_r + PW'(1);
        if (pend_vld_r[idx_r]) pend_wait_r[idx_r] <= s_wait;
        if (s_due) begin
          res_valid      <= 1'b1;
          emitted_r      <= 1'b1;
          res.hit        <= 1'b0;
          res.table_full <= 1'b0;
          res.found_mac  <= '0;
          res.target_ip  <= pend_ip_r[idx_r];
          res.last       <= !later_due;
          if (s_give_up) begin
            res.kind <= KIND_UNREACH;
            pend_vld_r[idx_r] <= 1'b0;
          end else begin
            res.kind <= KIND_SEND;
            pend_wait_r[idx_r] <= 4'd0;
            if (pend_sends_r[idx_r] != 4'd15)
              pend_sends_r[idx_r] <= pend_sends_r[idx_r] + 4'd1;
          end
        end
      end
    end
  end

endmodule

// ===== hdl/arp_ctrl.sv =====
// ----------------------------------------------------------------------------
// arp_ctrl
// Sequencer: accepts a beat, runs the command, walks the tick sweep and
// holds one output beat in a register; commands wait until it is free.
// ----------------------------------------------------------------------------
module arp_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_cmd,
  output arp_pkg::dp_cmd_t    cmd,
  input  arp_pkg::dp_sts_t    sts,
  input  logic                res_valid,
  input  arp_pkg::out_item_t  res,
  output logic                out_valid,
  input  logic                out_ready,
  output arp_pkg::out_item_t  out_data
);
  import arp_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_EXEC, ST_AGE, ST_SWEEP, ST_FINAL, ST_WAIT
  } state_t;

  state_t    state_r;
  logic      tick_r;
  out_item_t out_r;
  logic      out_vld_r;
  logic      out_free;

  // the datapath result is registered and lands in the cycle after the command, so a new
  // command only goes out when the output register is empty and no result is in flight
  assign out_free  = !out_vld_r && !res_valid;
  assign in_ready  = (state_r == ST_IDLE) && !res_valid && !out_vld_r;
  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  always_comb begin
    cmd = '0;
    unique case (state_r)
      ST_IDLE:  begin
        cmd.load      = in_valid && in_ready;
        cmd.sweep_clr = 1'b1;
      end
      ST_EXEC:  cmd.exec  = !tick_r && out_free;
      ST_AGE:   cmd.age   = 1'b1;
      ST_SWEEP: cmd.sweep = out_free;
      ST_FINAL: cmd.exec  = out_free && !sts.emitted;
      ST_WAIT:  cmd = '0;
      default:  cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      tick_r    <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (out_vld_r && out_ready) out_vld_r <= 1'b0;
      if (res_valid) begin
        out_vld_r <= 1'b1;
        out_r     <= res;
      end
      unique case (state_r)
        ST_IDLE: if (cmd.load) begin
          tick_r  <= (cmd_t'(in_cmd) == CMD_TICK);
          state_r <= ST_EXEC;
        end
        ST_EXEC: begin
          if (tick_r) state_r <= ST_AGE;
          else if (out_free) state_r <= ST_WAIT;
        end
        ST_AGE: state_r <= ST_SWEEP;
        ST_SWEEP: if (out_free && sts.sweep_done) state_r <= ST_FINAL;
        ST_FINAL: begin
          // sweep results already carry last; otherwise send the idle beat
          if (sts.emitted || out_free) state_r <= ST_WAIT;
        end
        ST_WAIT: if (!res_valid) state_r <= ST_IDLE;
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule
